@@ rtl/radix_number_formatter_macros.svh @@
// Assertion macros for the radix number formatter.
// Included by the top level; the macros use its i_clk and i_rst_n.
`ifndef RADIX_NUMBER_FORMATTER_MACROS_SVH
`define RADIX_NUMBER_FORMATTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RNF_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RNF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rnf_pkg.sv @@
// Shared types, codes and character helpers for the radix number formatter.
// Depends on nothing; used by the channel interfaces and the top level.
package rnf_pkg;

    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int DECIMAL     = 10;
    localparam int RADIX_MIN   = 2;
    localparam int RADIX_MAX   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_RADIX           = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRACTION_DIGITS = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef logic [CHAR_W-1:0] t_char;

    function automatic t_char digit_char(input logic [DIGIT_W-1:0] d);
        t_char c;
        if (d < DIGIT_W'(DECIMAL)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d) - CHAR_W'(DECIMAL);
        end
        return c;
    endfunction

endpackage

@@ rtl/rnf_if.sv @@
// Valid/ready channel interfaces of the radix number formatter:
// number input, character output and register writes. Uses rnf_pkg.
interface rnf_in_if #(
    parameter int WHOLE_BITS    = 31,
    parameter int FRACTION_BITS = 32
);
    logic                     valid;
    logic                     ready;
    logic                     is_negative;
    logic [WHOLE_BITS-1:0]    whole_magnitude;
    logic [FRACTION_BITS-1:0] fraction_magnitude;

    modport source(output valid, is_negative, whole_magnitude, fraction_magnitude,
                   input ready);
    modport sink(input valid, is_negative, whole_magnitude, fraction_magnitude,
                 output ready);
endinterface

interface rnf_out_if;
    import rnf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;

    modport source(output valid, text_char, last_char, input ready);
    modport sink(input valid, text_char, last_char, output ready);
endinterface

interface rnf_cfg_if;
    import rnf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/radix_number_formatter.sv @@
// Radix number formatter top level: converts sign, integer and fraction
// into base-N ASCII text. Uses rnf_pkg, rnf_if.sv, rnf_ram and the macros header.
//
//  channel   direction  beat contents
//  i_in      in         is_negative, whole_magnitude, fraction_magnitude
//  o_out     out        text_char, last_char
//  i_cfg     in         index, data (0: radix, 1: fraction_digits)
//
// Every digit passes through the shared multiplier into a registered product
// (a reciprocal multiply per integer digit, a radix multiply per fraction digit)
// and is then corrected and stored. Characters leave one a cycle from the digit
// RAM while the output accepts them.
// Reset (synchronous, active low) sets radix 10 and a fraction digit count of zero.
// The input is held off while a number is in work; a stalled output only
// pauses emission, and a new number is taken while the last character waits.
`include "radix_number_formatter_macros.svh"

module radix_number_formatter #(
    parameter int WHOLE_BITS          = 31,
    parameter int FRACTION_BITS       = 32,
    parameter int MAX_FRACTION_DIGITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rnf_in_if.sink    i_in,
    rnf_out_if.source o_out,
    rnf_cfg_if.sink   i_cfg
);
    import rnf_pkg::*;

    localparam int BUF_DEPTH = WHOLE_BITS + MAX_FRACTION_DIGITS;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int CW        = $clog2(WHOLE_BITS + 1);
    localparam int KW        = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int MAX_W     = (WHOLE_BITS > FRACTION_BITS) ? WHOLE_BITS : FRACTION_BITS;
    localparam int PROD_W    = MAX_W + WHOLE_BITS;
    localparam logic [WHOLE_BITS:0] RECIP_ONE = {1'b1, {WHOLE_BITS{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_INT_MUL,
        S_INT_FIX,
        S_FRAC_MUL,
        S_FRAC_FIX,
        S_OUT_START,
        S_OUT_SIGN,
        S_OUT_ZERO,
        S_OUT_INT,
        S_OUT_POINT,
        S_OUT_FRAC
    } t_state;

    t_state                   r_state, n_state;
    logic [RADIX_W-1:0]       r_radix, n_radix;
    logic [CFG_DATA_W-1:0]    r_fd, n_fd;
    logic                     r_sign, n_sign;
    logic [WHOLE_BITS-1:0]    r_q, n_q;
    logic [FRACTION_BITS-1:0] r_f, n_f;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [KW-1:0]            r_fi, n_fi;
    logic [KW-1:0]            r_keep, n_keep;
    logic [AW-1:0]            r_idx, n_idx;
    logic                     r_out_valid, n_out_valid;
    t_char                    r_out_char, n_out_char;
    logic                     r_out_last, n_out_last;

    // Shared multiplier operands.
    logic [MAX_W-1:0]         mul_a;
    logic [WHOLE_BITS-1:0]    mul_b;
    logic [WHOLE_BITS-1:0]    recip;

    // Integer digit correction.
    logic [WHOLE_BITS-1:0]    q_est;
    logic [WHOLE_BITS+RADIX_W-1:0] qr_wide;
    logic [WHOLE_BITS-1:0]    rem_full;
    logic [5:0]               rem6;
    logic [WHOLE_BITS-1:0]    q_next;
    logic [DIGIT_W-1:0]       int_digit;

    // Fraction digit development.
    logic [DIGIT_W-1:0]       frac_hi;
    logic [RADIX_W-1:0]       frac_rnd;
    logic [RADIX_W-1:0]       frac_clamped;
    logic [RADIX_W-1:0]       nd;
    logic                     frac_is_last;
    logic [DIGIT_W-1:0]       frac_digit;

    logic                     we;
    logic [AW-1:0]            wr_addr;
    logic [DIGIT_W-1:0]       wr_digit;
    logic [DIGIT_W-1:0]       rd_digit;
    logic [AW-1:0]            frac_last_addr;
    logic                     can_push;
    logic                     push;
    t_char                    push_char;
    logic                     push_last;
    logic [CFG_DATA_W-1:0]    cfg_v;

    rnf_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (BUF_DEPTH),
        .ADDR_W(AW)
    ) u_digits (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(wr_addr),
        .i_wdata(wr_digit),
        .i_raddr(n_idx),
        .o_rdata(rd_digit)
    );

    // Truncated reciprocal 2^WHOLE_BITS / radix; the estimate is low by at most one.
    always_comb begin
        case (r_radix)
            5'd2:    recip = WHOLE_BITS'(RECIP_ONE / 2);
            5'd3:    recip = WHOLE_BITS'(RECIP_ONE / 3);
            5'd4:    recip = WHOLE_BITS'(RECIP_ONE / 4);
            5'd5:    recip = WHOLE_BITS'(RECIP_ONE / 5);
            5'd6:    recip = WHOLE_BITS'(RECIP_ONE / 6);
            5'd7:    recip = WHOLE_BITS'(RECIP_ONE / 7);
            5'd8:    recip = WHOLE_BITS'(RECIP_ONE / 8);
            5'd9:    recip = WHOLE_BITS'(RECIP_ONE / 9);
            5'd10:   recip = WHOLE_BITS'(RECIP_ONE / 10);
            5'd11:   recip = WHOLE_BITS'(RECIP_ONE / 11);
            5'd12:   recip = WHOLE_BITS'(RECIP_ONE / 12);
            5'd13:   recip = WHOLE_BITS'(RECIP_ONE / 13);
            5'd14:   recip = WHOLE_BITS'(RECIP_ONE / 14);
            5'd15:   recip = WHOLE_BITS'(RECIP_ONE / 15);
            5'd16:   recip = WHOLE_BITS'(RECIP_ONE / 16);
            default: recip = '0;
        endcase
    end

    always_comb begin
        if (r_state == S_INT_MUL) begin
            mul_a = MAX_W'(r_q);
            mul_b = recip;
        end else begin
            mul_a = MAX_W'(r_f);
            mul_b = WHOLE_BITS'(r_radix);
        end
        n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb begin
        q_est    = r_prod[WHOLE_BITS +: WHOLE_BITS];
        qr_wide  = (WHOLE_BITS + RADIX_W)'(q_est) * (WHOLE_BITS + RADIX_W)'(r_radix);
        rem_full = r_q - qr_wide[WHOLE_BITS-1:0];
        rem6     = rem_full[5:0];
        if (rem6 >= 6'(r_radix)) begin
            int_digit = DIGIT_W'(rem6 - 6'(r_radix));
            q_next    = q_est + WHOLE_BITS'(1);
        end else begin
            int_digit = DIGIT_W'(rem6);
            q_next    = q_est;
        end
    end

    always_comb begin
        nd           = (r_fd == '0) ? RADIX_W'(1) : RADIX_W'(r_fd);
        frac_is_last = (6'(r_fi) + 6'd1) == 6'(nd);
        frac_hi      = r_prod[FRACTION_BITS +: DIGIT_W];
        // Round half up on the last digit, then keep it below the radix.
        frac_rnd     = RADIX_W'(frac_hi) + RADIX_W'(r_prod[FRACTION_BITS-1]);
        frac_clamped = (frac_rnd >= r_radix) ? (r_radix - RADIX_W'(1)) : frac_rnd;
        frac_digit   = frac_is_last ? DIGIT_W'(frac_clamped) : frac_hi;
    end

    always_comb begin
        we       = (r_state == S_INT_FIX) || (r_state == S_FRAC_FIX);
        wr_addr  = (r_state == S_INT_FIX) ? AW'(r_cnt) : AW'(WHOLE_BITS) + AW'(r_fi);
        wr_digit = (r_state == S_INT_FIX) ? int_digit : frac_digit;
    end

    assign frac_last_addr = AW'(WHOLE_BITS) + AW'(r_keep) - AW'(1);
    assign can_push       = !r_out_valid || o_out.ready;
    assign cfg_v          = i_cfg.data;

    always_comb begin
        n_state   = r_state;
        n_radix   = r_radix;
        n_fd      = r_fd;
        n_sign    = r_sign;
        n_q       = r_q;
        n_f       = r_f;
        n_cnt     = r_cnt;
        n_fi      = r_fi;
        n_keep    = r_keep;
        n_idx     = r_idx;
        push      = 1'b0;
        push_char = CHAR_ZERO;
        push_last = 1'b0;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RADIX: begin
                    if (cfg_v < CFG_DATA_W'(RADIX_MIN)) begin
                        n_radix = RADIX_W'(RADIX_MIN);
                    end else if (cfg_v > CFG_DATA_W'(RADIX_MAX)) begin
                        n_radix = RADIX_W'(RADIX_MAX);
                    end else begin
                        n_radix = RADIX_W'(cfg_v);
                    end
                end
                REG_FRACTION_DIGITS: begin
                    if (32'(cfg_v) > MAX_FRACTION_DIGITS) begin
                        n_fd = CFG_DATA_W'(MAX_FRACTION_DIGITS);
                    end else begin
                        n_fd = cfg_v;
                    end
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_q    = i_in.whole_magnitude;
                    n_f    = i_in.fraction_magnitude;
                    n_sign = i_in.is_negative &&
                             (i_in.whole_magnitude != '0 || i_in.fraction_magnitude != '0);
                    n_cnt  = '0;
                    n_fi   = '0;
                    n_keep = '0;
                    if (i_in.whole_magnitude != '0) begin
                        n_state = S_INT_MUL;
                    end else if (i_in.fraction_magnitude != '0) begin
                        n_state = S_FRAC_MUL;
                    end else begin
                        n_state = S_OUT_START;
                    end
                end
            end
            S_INT_MUL: begin
                n_state = S_INT_FIX;
            end
            S_INT_FIX: begin
                n_q   = q_next;
                n_cnt = r_cnt + CW'(1);
                if (q_next != '0 && (32'(r_cnt) + 1) < WHOLE_BITS) begin
                    n_state = S_INT_MUL;
                end else if (r_f != '0) begin
                    n_state = S_FRAC_MUL;
                end else begin
                    n_state = S_OUT_START;
                end
            end
            S_FRAC_MUL: begin
                n_state = S_FRAC_FIX;
            end
            S_FRAC_FIX: begin
                n_f  = r_prod[FRACTION_BITS-1:0];
                n_fi = r_fi + KW'(1);
                if (frac_digit != '0) begin
                    n_keep = r_fi + KW'(1);
                end
                n_state = frac_is_last ? S_OUT_START : S_FRAC_MUL;
            end
            S_OUT_START: begin
                // Point the read port at the most significant integer digit.
                n_idx = AW'(r_cnt) - AW'(1);
                if (r_sign) begin
                    n_state = S_OUT_SIGN;
                end else if (r_cnt == '0) begin
                    n_state = S_OUT_ZERO;
                end else begin
                    n_state = S_OUT_INT;
                end
            end
            S_OUT_SIGN: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_char = CHAR_MINUS;
                    n_state   = (r_cnt == '0) ? S_OUT_ZERO : S_OUT_INT;
                end
            end
            S_OUT_ZERO: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_char = CHAR_ZERO;
                    push_last = (r_keep == '0);
                    n_idx     = AW'(WHOLE_BITS);
                    n_state   = (r_keep == '0) ? S_IDLE : S_OUT_POINT;
                end
            end
            S_OUT_INT: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_char = digit_char(rd_digit);
                    if (r_idx == '0) begin
                        push_last = (r_keep == '0);
                        n_idx     = AW'(WHOLE_BITS);
                        n_state   = (r_keep == '0) ? S_IDLE : S_OUT_POINT;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            S_OUT_POINT: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_char = CHAR_POINT;
                    n_state   = S_OUT_FRAC;
                end
            end
            S_OUT_FRAC: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_char = digit_char(rd_digit);
                    if (r_idx == frac_last_addr) begin
                        push_last = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (push) begin
            n_out_valid = 1'b1;
            n_out_char  = push_char;
            n_out_last  = push_last;
        end else begin
            n_out_valid = r_out_valid && !o_out.ready;
            n_out_char  = r_out_char;
            n_out_last  = r_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_W'(DECIMAL);
            r_fd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_radix     <= n_radix;
            r_fd        <= n_fd;
            r_out_valid <= n_out_valid;
        end
        r_sign     <= n_sign;
        r_q        <= n_q;
        r_f        <= n_f;
        r_prod     <= n_prod;
        r_cnt      <= n_cnt;
        r_fi       <= n_fi;
        r_keep     <= n_keep;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.text_char = r_out_char;
    assign o_out.last_char = r_out_last;

    `RNF_CHECK(a_digit_below_radix, we, RADIX_W'(wr_digit) < r_radix, "digit not below radix")
    `RNF_CHECK_NEXT(a_q_shrinks, r_state == S_INT_FIX, r_q < $past(r_q), "quotient not reduced")
    `RNF_CHECK(a_frac_bound, r_state == S_FRAC_FIX, 6'(r_fi) < 6'(nd), "fraction index too high")

endmodule

@@ rtl/rnf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rnf_ram #(
    parameter int WIDTH  = 4,
    parameter int DEPTH  = 55,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
